/* hw/rtl/dvd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dvd_pkg
// Shared types, constants and helpers for the 256-bit integer divider.
// ---------------------------------------------------------------------------
package dvd_pkg;

    localparam int DVD_W  = 256;
    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(DVD_W);

    // operation codes carried in req_type
    localparam logic [1:0] OP_UDIV = 2'd0;
    localparam logic [1:0] OP_UMOD = 2'd1;
    localparam logic [1:0] OP_SDIV = 2'd2;
    localparam logic [1:0] OP_SMOD = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] dividend_w0;
        logic [WORD_W-1:0] dividend_w1;
        logic [WORD_W-1:0] dividend_w2;
        logic [WORD_W-1:0] dividend_w3;
        logic [WORD_W-1:0] divisor_w0;
        logic [WORD_W-1:0] divisor_w1;
        logic [WORD_W-1:0] divisor_w2;
        logic [WORD_W-1:0] divisor_w3;
    } dvd_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] answer_w0;
        logic [WORD_W-1:0] answer_w1;
        logic [WORD_W-1:0] answer_w2;
        logic [WORD_W-1:0] answer_w3;
    } dvd_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_FIX
    } dvd_state_t;

    // two's complement negate
    function automatic logic [DVD_W-1:0] dvd_neg(input logic [DVD_W-1:0] x);
        dvd_neg = (~x) + DVD_W'(1);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/dvd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dvd_core
// Restoring shift-subtract unit: one quotient bit per cycle, 256 quotient bits per divide.
// ---------------------------------------------------------------------------
module dvd_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [dvd_pkg::DVD_W-1:0] num,
    input  wire logic [dvd_pkg::DVD_W-1:0] den,
    output logic                           last,
    output logic [dvd_pkg::DVD_W-1:0]      quo,
    output logic [dvd_pkg::DVD_W-1:0]      rem
);

    logic                           run_reg, run_next;
    logic [dvd_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [dvd_pkg::DVD_W-1:0]      num_reg, num_next;   // dividend out, quotient in
    logic [dvd_pkg::DVD_W-1:0]      rem_reg, rem_next;
    logic [dvd_pkg::DVD_W-1:0]      den_reg, den_next;
    logic [dvd_pkg::DVD_W:0]        part;
    logic [dvd_pkg::DVD_W+1:0]      trial;
    logic                           fits;

    // one trial subtraction of the shifted partial remainder
    always_comb begin
        part  = {rem_reg, num_reg[dvd_pkg::DVD_W-1]};
        trial = {1'b0, part} - {2'b00, den_reg};
        fits  = !trial[dvd_pkg::DVD_W+1];
    end

    always_comb begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = dvd_pkg::CNT_W'(dvd_pkg::DVD_W - 1);
            num_next = num;
            rem_next = '0;
            den_next = den;
        end else if (run_reg) begin
            rem_next = fits ? trial[dvd_pkg::DVD_W-1:0] : part[dvd_pkg::DVD_W-1:0];
            num_next = {num_reg[dvd_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg - dvd_pkg::CNT_W'(1);
            if (cnt_reg == '0) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign last = run_reg && (cnt_reg == '0);
    assign quo  = num_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

/* hw/rtl/divider_256bit_signed_unsigned.sv */
`timescale 1ns / 1ps
`default_nettype none
// A request passes through sign prep, the bit-serial core steps and a sign fixup before m_valid.
// The shift-subtract core produces one quotient bit per cycle and handles one
// request at a time.
// A finished answer waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_valid.
// ---------------------------------------------------------------------------
// divider_256bit_signed_unsigned
// 256-bit signed/unsigned divide and modulo with a bit-serial divider core.
// ---------------------------------------------------------------------------
module divider_256bit_signed_unsigned (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dvd_pkg::dvd_req_t s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dvd_pkg::dvd_rsp_t      m_rsp
);

    dvd_pkg::dvd_state_t             state_reg, state_next;
    logic [1:0]                      op_reg, op_next;
    logic [dvd_pkg::DVD_W-1:0]       a_reg, a_next;
    logic [dvd_pkg::DVD_W-1:0]       b_reg, b_next;
    logic                            a_neg_reg, a_neg_next;
    logic                            b_neg_reg, b_neg_next;
    logic                            dz_reg, dz_next;
    logic                            m_valid_reg, m_valid_next;
    dvd_pkg::dvd_rsp_t               rsp_reg, rsp_next;

    logic                            accept;
    logic                            sgn;
    logic                            out_free;
    logic                            core_start;
    logic                            core_last;
    logic [dvd_pkg::DVD_W-1:0]       num_mag, den_mag;
    logic [dvd_pkg::DVD_W-1:0]       core_quo, core_rem;
    logic [dvd_pkg::DVD_W-1:0]       sel, answer;
    logic                            flip;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign sgn      = (op_reg == dvd_pkg::OP_SDIV) || (op_reg == dvd_pkg::OP_SMOD);

    // operand magnitudes for the core
    always_comb begin
        num_mag = (sgn && a_reg[dvd_pkg::DVD_W-1]) ? dvd_pkg::dvd_neg(a_reg) : a_reg;
        den_mag = (sgn && b_reg[dvd_pkg::DVD_W-1]) ? dvd_pkg::dvd_neg(b_reg) : b_reg;
    end

    dvd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .num     (num_mag),
        .den     (den_mag),
        .last    (core_last),
        .quo     (core_quo),
        .rem     (core_rem)
    );

    // result select and sign fixup
    always_comb begin
        if (op_reg == dvd_pkg::OP_UMOD || op_reg == dvd_pkg::OP_SMOD) begin
            sel  = core_rem;
            flip = (op_reg == dvd_pkg::OP_SMOD) && a_neg_reg;
        end else begin
            sel  = core_quo;
            flip = (op_reg == dvd_pkg::OP_SDIV) && (a_neg_reg != b_neg_reg);
        end
        if (dz_reg) begin
            answer = '0;
        end else if (flip) begin
            answer = dvd_pkg::dvd_neg(sel);
        end else begin
            answer = sel;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dvd_pkg::ST_IDLE: begin
                if (accept) state_next = dvd_pkg::ST_PREP;
            end
            dvd_pkg::ST_PREP: begin
                state_next = dvd_pkg::ST_RUN;
            end
            dvd_pkg::ST_RUN: begin
                if (core_last) state_next = dvd_pkg::ST_FIX;
            end
            dvd_pkg::ST_FIX: begin
                if (out_free) state_next = dvd_pkg::ST_IDLE;
            end
            default: begin
                state_next = dvd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        s_ready      = 1'b0;
        core_start   = 1'b0;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        a_neg_next   = a_neg_reg;
        b_neg_next   = b_neg_reg;
        dz_next      = dz_reg;
        rsp_next     = rsp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            dvd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    op_next = s_req.req_type;
                    a_next  = {s_req.dividend_w3, s_req.dividend_w2,
                               s_req.dividend_w1, s_req.dividend_w0};
                    b_next  = {s_req.divisor_w3, s_req.divisor_w2,
                               s_req.divisor_w1, s_req.divisor_w0};
                end
            end
            dvd_pkg::ST_PREP: begin
                core_start = 1'b1;
                a_neg_next = sgn && a_reg[dvd_pkg::DVD_W-1];
                b_neg_next = sgn && b_reg[dvd_pkg::DVD_W-1];
                dz_next    = (b_reg == '0);
            end
            dvd_pkg::ST_RUN: begin
            end
            dvd_pkg::ST_FIX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    rsp_next     = '{answer_w0: answer[63:0],
                                     answer_w1: answer[127:64],
                                     answer_w2: answer[191:128],
                                     answer_w3: answer[255:192]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dvd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        dz_reg    <= dz_next;
        rsp_reg   <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

endmodule
`default_nettype wire

/* hw/rtl/dvd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dvd_checker
// Port-level checks for the divider, bound to the top level.
// ---------------------------------------------------------------------------
module dvd_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire dvd_pkg::dvd_rsp_t m_rsp
);

    // a held answer stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("answer dropped before taken");

    // a held answer keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_rsp))
        else $error("answer changed while stalled");

    // one request in work at a time
    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !s_valid || !s_ready)
        else $error("request taken while busy");

    // no answer appears in the cycle after a request taken while none is offered
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("answer before divide finished");

    // reset leaves the block idle and empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind divider_256bit_signed_unsigned dvd_checker u_dvd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);
`default_nettype wire

/* verif/divider_256bit_signed_unsigned_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// divider_256bit_signed_unsigned_test
// Self-checking bench for the 256-bit divider: requests of all four
// operations go in over the valid/ready channel, each answer is compared
// word by word against a native wide-arithmetic prediction, with random
// gaps on both sides, a long output hold-off and idle pauses.
// ---------------------------------------------------------------------------
module divider_256bit_signed_unsigned_test;

    localparam logic [255:0] MIN_VAL = {1'b1, {255{1'b0}}};
    localparam logic [255:0] NEG_ONE = {256{1'b1}};
    localparam int           GAP_MAX = 17;

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    dvd_pkg::dvd_req_t s_req   = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    dvd_pkg::dvd_rsp_t m_rsp;

    dvd_pkg::dvd_rsp_t pending_answers[$];
    int                error_count = 0;
    int                send_gap_max = GAP_MAX;
    int                recv_stall_max = GAP_MAX;
    int                hold_off_cycles = 0;

    divider_256bit_signed_unsigned dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // expected answer of one request
    function automatic dvd_pkg::dvd_rsp_t divide_answer(input dvd_pkg::dvd_req_t r);
        logic [255:0]      num, den, quo, rem, ans;
        logic              num_neg, den_neg, signed_op;
        dvd_pkg::dvd_rsp_t rsp;
        num = {r.dividend_w3, r.dividend_w2, r.dividend_w1, r.dividend_w0};
        den = {r.divisor_w3, r.divisor_w2, r.divisor_w1, r.divisor_w0};
        signed_op = (r.req_type == dvd_pkg::OP_SDIV) || (r.req_type == dvd_pkg::OP_SMOD);
        num_neg = signed_op && num[255];
        den_neg = signed_op && den[255];
        if (den == '0) begin
            ans = '0;
        end else begin
            // magnitudes; the minimum value maps onto itself, which is 2^255 unsigned
            if (num_neg) num = 256'd0 - num;
            if (den_neg) den = 256'd0 - den;
            quo = num / den;
            rem = num % den;
            case (r.req_type)
                dvd_pkg::OP_UDIV: ans = quo;
                dvd_pkg::OP_UMOD: ans = rem;
                dvd_pkg::OP_SDIV: ans = ((num_neg != den_neg) && quo != '0) ? 256'd0 - quo : quo;
                default:          ans = (num_neg && rem != '0) ? 256'd0 - rem : rem;
            endcase
        end
        rsp.answer_w0 = ans[63:0];
        rsp.answer_w1 = ans[127:64];
        rsp.answer_w2 = ans[191:128];
        rsp.answer_w3 = ans[255:192];
        return rsp;
    endfunction

    function automatic dvd_pkg::dvd_req_t make_request(input logic [1:0] op,
                                                       input logic [255:0] a,
                                                       input logic [255:0] b);
        dvd_pkg::dvd_req_t r;
        r.req_type    = op;
        r.dividend_w0 = a[63:0];
        r.dividend_w1 = a[127:64];
        r.dividend_w2 = a[191:128];
        r.dividend_w3 = a[255:192];
        r.divisor_w0  = b[63:0];
        r.divisor_w1  = b[127:64];
        r.divisor_w2  = b[191:128];
        r.divisor_w3  = b[255:192];
        return r;
    endfunction

    // operand shapes: full width, varied magnitude, small, negative, powers of two, extremes
    function automatic logic [255:0] random_operand();
        logic [255:0] v;
        for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
        case ($urandom_range(0, 7))
            2: v = v >> $urandom_range(1, 255);
            3: v = 256'($urandom_range(0, 15));
            4: v = 256'd0 - 256'($urandom_range(1, 15));
            5: v = 256'd1 << $urandom_range(0, 255);
            6: v = 256'd0 - (v >> $urandom_range(1, 255));
            7: begin
                case ($urandom_range(0, 2))
                    0:       v = MIN_VAL;
                    1:       v = NEG_ONE;
                    default: v = ~MIN_VAL;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic dvd_pkg::dvd_req_t random_request();
        logic [1:0] op;
        case ($urandom_range(0, 3))
            0:       op = dvd_pkg::OP_UDIV;
            1:       op = dvd_pkg::OP_UMOD;
            2:       op = dvd_pkg::OP_SDIV;
            default: op = dvd_pkg::OP_SMOD;
        endcase
        return make_request(op, random_operand(), random_operand());
    endfunction

    // one request: optional gap, then hold valid until accepted
    task automatic send_request(input dvd_pkg::dvd_req_t req);
        int gap;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        do @(posedge aclk); while (!s_ready);
        pending_answers.push_back(divide_answer(req));
    endtask

    task automatic send_all_ops(input logic [255:0] a, input logic [255:0] b);
        send_request(make_request(dvd_pkg::OP_UDIV, a, b));
        send_request(make_request(dvd_pkg::OP_UMOD, a, b));
        send_request(make_request(dvd_pkg::OP_SDIV, a, b));
        send_request(make_request(dvd_pkg::OP_SMOD, a, b));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    // drop valid and wait for every outstanding answer
    task automatic pause_until_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_answers.size() != 0);
    endtask

    // compare one accepted answer with the oldest prediction
    task automatic check_answer(input dvd_pkg::dvd_rsp_t got);
        dvd_pkg::dvd_rsp_t want;
        if (pending_answers.size() == 0) begin
            $error("answer with no request outstanding: %h", got);
            error_count++;
        end else begin
            want = pending_answers.pop_front();
            // answer_w0 sits in the top bits of the packed struct
            for (int i = 0; i < 4; i++) begin
                if (got[(3-i)*64 +: 64] !== want[(3-i)*64 +: 64]) begin
                    $error("answer_w%0d mismatch: expected %h, actual %h",
                           i, want[(3-i)*64 +: 64], got[(3-i)*64 +: 64]);
                    error_count++;
                end
            end
        end
    endtask

    // answer side: random stall, or a long hold-off when one is requested
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles != 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_answer(m_rsp);
        end
    end

    // division by zero, minimum over minus one, extremes and every sign pairing with a negative operand
    task automatic test_special_operands();
        send_all_ops(MIN_VAL, '0);
        send_all_ops(MIN_VAL, NEG_ONE);
        send_all_ops(NEG_ONE, 256'd1);
        send_all_ops(256'd0 - 256'd7, 256'd2);
        send_all_ops(256'd7, 256'd0 - 256'd2);
        // exact negative division: zero remainder must stay unsigned zero
        send_all_ops(256'd0 - 256'd6, 256'd0 - 256'd3);
    endtask

    task automatic test_random_traffic();
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
        send_random(1030);
    endtask

    task automatic test_back_to_back();
        send_gap_max   = 0;
        recv_stall_max = 0;
        send_random(150);
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_hold_off();
        send_gap_max    = 0;
        hold_off_cycles = 1500;
        send_random(8);
        send_gap_max    = GAP_MAX;
        pause_until_idle();
    endtask

    task automatic test_idle_restart();
        repeat (4) begin
            send_random(60);
            pause_until_idle();
        end
    endtask

    // sequence
    initial begin
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_operands();
        test_output_hold_off();
        test_back_to_back();
        test_random_traffic();
        test_idle_restart();

        pause_until_idle();
        repeat (300) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
